[src/c2s_pkg.sv]
// Package for the Cartesian-to-spherical converter.
// Holds transaction types and fixed-point constants; no dependencies.
package c2s_pkg;

    localparam int CoordW = 16;
    localparam int SqW    = 32;
    localparam int RootW  = 16;
    localparam int QW     = 15;
    localparam int NumW   = CoordW + 1;
    localparam int LimW   = 8;

    localparam logic signed [CoordW-1:0] QOne  = 16'sd32767;
    localparam logic signed [CoordW-1:0] QZero = 16'sd0;

    typedef struct packed {
        logic signed [CoordW-1:0] coord_x;
        logic signed [CoordW-1:0] coord_y;
        logic signed [CoordW-1:0] coord_z;
    } c2s_in_t;

    typedef struct packed {
        logic        [RootW-1:0]  radius;
        logic signed [CoordW-1:0] cos_theta;
        logic        [QW-1:0]     sin_theta;
        logic signed [CoordW-1:0] cos_phi;
        logic signed [CoordW-1:0] sin_phi;
    } c2s_out_t;

endpackage

[src/c2s_sqrt.sv]
// Pipelined integer square root, one result bit per stage.
// Depends on c2s_pkg.
module c2s_sqrt (
    input  logic                     aclk,
    input  logic                     en,
    input  logic [c2s_pkg::SqW-1:0]  val,
    output logic [c2s_pkg::RootW-1:0] root
);
    import c2s_pkg::*;

    localparam int N    = RootW;
    localparam int RemW = RootW + 1;

    logic [SqW-1:0]  src_v    [N];
    logic [RemW-1:0] src_rem  [N];
    logic [RootW-1:0] src_root [N];
    logic [SqW-1:0]  v_next    [N];
    logic [RemW-1:0] rem_next  [N];
    logic [RootW-1:0] root_next [N];
    logic [SqW-1:0]  v_reg    [N];
    logic [RemW-1:0] rem_reg  [N];
    logic [RootW-1:0] root_reg [N];
    logic [RemW+1:0] shifted  [N];
    logic [RemW:0]   trial    [N];

    always_comb begin
        src_v[0]    = val;
        src_rem[0]  = '0;
        src_root[0] = '0;
        for (int k = 1; k < N; k++) begin
            src_v[k]    = v_reg[k-1];
            src_rem[k]  = rem_reg[k-1];
            src_root[k] = root_reg[k-1];
        end
        for (int k = 0; k < N; k++) begin
            shifted[k] = {src_rem[k], src_v[k][SqW-1 -: 2]};
            trial[k]   = {src_root[k], 2'b01};
            v_next[k]  = {src_v[k][SqW-3:0], 2'b00};
            if (shifted[k] >= {1'b0, trial[k]}) begin
                rem_next[k]  = RemW'(shifted[k] - {1'b0, trial[k]});
                root_next[k] = {src_root[k][RootW-2:0], 1'b1};
            end else begin
                rem_next[k]  = shifted[k][RemW-1:0];
                root_next[k] = {src_root[k][RootW-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int k = 0; k < N; k++) begin
                v_reg[k]    <= v_next[k];
                rem_reg[k]  <= rem_next[k];
                root_reg[k] <= root_next[k];
            end
        end
    end

    assign root = root_reg[N-1];

endmodule

[src/c2s_div.sv]
// Pipelined Q1.15 divider: saturation test, then one quotient bit a stage.
// Depends on c2s_pkg.
module c2s_div (
    input  logic                              aclk,
    input  logic                              en,
    input  logic signed [c2s_pkg::NumW-1:0]   num,
    input  logic        [c2s_pkg::RootW-1:0]  den,
    output logic signed [c2s_pkg::CoordW-1:0] quo
);
    import c2s_pkg::*;

    localparam int N = QW + 1;

    logic [NumW-1:0]  mag;
    logic             neg_reg [N];
    logic             sat_reg [N];
    logic [RootW-1:0] den_reg [N];
    logic [RootW-1:0] rem_reg [N];
    logic [QW-1:0]    q_reg   [N];
    logic [RootW:0]   rem2    [N];
    logic             ge      [N];
    logic [CoordW-1:0] res_mag;

    always_comb begin
        mag = num[NumW-1] ? NumW'(-num) : NumW'(num);
        rem2[0] = '0;
        ge[0]   = 1'b0;
        for (int k = 1; k < N; k++) begin
            rem2[k] = {rem_reg[k-1], 1'b0};
            ge[k]   = rem2[k] >= {1'b0, den_reg[k-1]};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            neg_reg[0] <= num[NumW-1];
            sat_reg[0] <= mag >= NumW'(den);
            den_reg[0] <= den;
            rem_reg[0] <= mag[RootW-1:0];
            q_reg[0]   <= '0;
            for (int k = 1; k < N; k++) begin
                neg_reg[k] <= neg_reg[k-1];
                sat_reg[k] <= sat_reg[k-1];
                den_reg[k] <= den_reg[k-1];
                rem_reg[k] <= ge[k] ? RootW'(rem2[k] - {1'b0, den_reg[k-1]})
                                    : rem2[k][RootW-1:0];
                q_reg[k]   <= {q_reg[k-1][QW-2:0], ge[k]};
            end
        end
    end

    assign res_mag = sat_reg[N-1] ? QOne : {1'b0, q_reg[N-1]};
    assign quo     = neg_reg[N-1] ? -$signed(res_mag) : $signed(res_mag);

endmodule

[src/cartesian_to_spherical.sv]
// Top level of the Cartesian-to-spherical converter.
// Depends on c2s_pkg, c2s_sqrt and c2s_div.
//
// Usage:
//   s_valid/s_ready/s_data carry one point (coord_x, coord_y, coord_z) per
//   transaction; m_valid/m_ready/m_data carry the radius, the Q1.15 cosines
//   of both angles, the Q1.15 azimuth sine and the Q0.15 polar sine.
//   cfg_valid/cfg_ready/cfg_data write zero_limit; cfg_ready is always high.
//   Write it only while no transaction is in flight.
// Pipeline: thirty-six register stages: two form the squares and sums,
//   sixteen the square roots (one root bit a stage), one the zero tests,
//   sixteen the quotients (saturation test and fifteen quotient bits) and
//   one the output register.
// Throughput: one transaction per cycle while the output is not held.
// Reset: aresetn clears every valid bit and sets zero_limit to zero.
// Stall: when m_valid is high and m_ready low the whole pipeline holds and
//   s_ready drops; bubbles keep flowing while the output register is empty.
module cartesian_to_spherical (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  c2s_pkg::c2s_in_t          s_data,
    output logic                      m_valid,
    input  logic                      m_ready,
    output c2s_pkg::c2s_out_t         m_data,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [c2s_pkg::LimW-1:0]  cfg_data
);
    import c2s_pkg::*;

    localparam int SqrtLat = RootW;
    localparam int DivLat  = QW + 1;
    localparam int CrdLen  = 2 + SqrtLat;
    localparam int VldLen  = CrdLen + 1 + DivLat;

    logic              en;
    logic [LimW-1:0]   zero_limit_reg;
    logic              vld_reg [VldLen];
    c2s_in_t           crd_reg [CrdLen];
    logic [SqW-2:0]    xx_reg, yy_reg, zz_reg;
    logic [SqW-1:0]    sxy_reg, sxyz_reg;
    logic [RootW-1:0]  r_root, rxy_root;
    logic [RootW-1:0]  r_reg, rxy_reg;
    logic              rz_reg, pz_reg;
    c2s_in_t           p3_reg;
    logic [RootW-1:0]  rd_reg [DivLat];
    logic              rzd_reg [DivLat];
    logic              pzd_reg [DivLat];
    logic signed [CoordW-1:0] ct, st, cp, sp;
    logic signed [CoordW*2-1:0] xsq, ysq, zsq;
    logic              m_valid_reg;
    c2s_out_t          m_data_reg;
    c2s_out_t          m_data_next;

    assign en        = !m_valid_reg || m_ready;
    assign s_ready   = en;
    assign cfg_ready = 1'b1;
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;

    assign xsq = s_data.coord_x * s_data.coord_x;
    assign ysq = s_data.coord_y * s_data.coord_y;
    assign zsq = s_data.coord_z * s_data.coord_z;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            zero_limit_reg <= '0;
            m_valid_reg    <= 1'b0;
            for (int k = 0; k < VldLen; k++) begin
                vld_reg[k] <= 1'b0;
            end
        end else begin
            if (cfg_valid) begin
                zero_limit_reg <= cfg_data;
            end
            if (en) begin
                vld_reg[0] <= s_valid;
                for (int k = 1; k < VldLen; k++) begin
                    vld_reg[k] <= vld_reg[k-1];
                end
                m_valid_reg <= vld_reg[VldLen-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            xx_reg     <= xsq[SqW-2:0];
            yy_reg     <= ysq[SqW-2:0];
            zz_reg     <= zsq[SqW-2:0];
            crd_reg[0] <= s_data;
            for (int k = 1; k < CrdLen; k++) begin
                crd_reg[k] <= crd_reg[k-1];
            end
            sxy_reg  <= {1'b0, xx_reg} + {1'b0, yy_reg};
            sxyz_reg <= {1'b0, xx_reg} + {1'b0, yy_reg} + {1'b0, zz_reg};
            r_reg    <= r_root;
            rxy_reg  <= rxy_root;
            rz_reg   <= r_root <= RootW'(zero_limit_reg);
            pz_reg   <= rxy_root <= RootW'(zero_limit_reg);
            p3_reg   <= crd_reg[CrdLen-1];
            rd_reg[0]  <= r_reg;
            rzd_reg[0] <= rz_reg;
            pzd_reg[0] <= pz_reg;
            for (int k = 1; k < DivLat; k++) begin
                rd_reg[k]  <= rd_reg[k-1];
                rzd_reg[k] <= rzd_reg[k-1];
                pzd_reg[k] <= pzd_reg[k-1];
            end
            m_data_reg <= m_data_next;
        end
    end

    c2s_sqrt u_sqrt_r (
        .aclk (aclk), .en (en), .val (sxyz_reg), .root (r_root)
    );

    c2s_sqrt u_sqrt_rxy (
        .aclk (aclk), .en (en), .val (sxy_reg), .root (rxy_root)
    );

    c2s_div u_div_ct (
        .aclk (aclk), .en (en), .num (NumW'(p3_reg.coord_z)), .den (r_reg), .quo (ct)
    );

    c2s_div u_div_st (
        .aclk (aclk), .en (en), .num ({1'b0, rxy_reg}), .den (r_reg), .quo (st)
    );

    c2s_div u_div_cp (
        .aclk (aclk), .en (en), .num (NumW'(p3_reg.coord_x)), .den (rxy_reg), .quo (cp)
    );

    c2s_div u_div_sp (
        .aclk (aclk), .en (en), .num (NumW'(p3_reg.coord_y)), .den (rxy_reg), .quo (sp)
    );

    always_comb begin
        m_data_next.radius = rd_reg[DivLat-1];
        if (rzd_reg[DivLat-1]) begin
            m_data_next.cos_theta = QOne;
            m_data_next.sin_theta = '0;
        end else begin
            m_data_next.cos_theta = ct;
            m_data_next.sin_theta = st[QW-1:0];
        end
        if (rzd_reg[DivLat-1] || pzd_reg[DivLat-1]) begin
            m_data_next.cos_phi = QOne;
            m_data_next.sin_phi = QZero;
        end else begin
            m_data_next.cos_phi = cp;
            m_data_next.sin_phi = sp;
        end
    end

endmodule

[src/c2s_checker.sv]
// Port-level checker for the Cartesian-to-spherical converter, bound to the top.
// Depends on c2s_pkg and cartesian_to_spherical.
module c2s_checker (
    input logic                      aclk,
    input logic                      aresetn,
    input logic                      s_valid,
    input logic                      s_ready,
    input c2s_pkg::c2s_in_t          s_data,
    input logic                      m_valid,
    input logic                      m_ready,
    input c2s_pkg::c2s_out_t         m_data,
    input logic                      cfg_valid,
    input logic                      cfg_ready,
    input logic [c2s_pkg::LimW-1:0]  cfg_data
);
    import c2s_pkg::*;

    logic unused_ok;
    assign unused_ok = s_valid ^ (^s_data) ^ cfg_valid ^ (^cfg_data);

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result transaction changed while held");

    a_drain: assert property (@(posedge aclk) disable iff (!aresetn)
        (!m_valid || m_ready) |-> s_ready)
        else $error("input refused while output can advance");

    a_rst: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    a_sat: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.cos_theta != 16'sh8000) && (m_data.cos_phi != 16'sh8000)
                    && (m_data.sin_phi != 16'sh8000))
        else $error("ratio outside saturation range");

    a_cfg: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_ready)
        else $error("configuration write refused");

endmodule

bind cartesian_to_spherical c2s_checker u_c2s_checker (.*);

[test/cartesian_to_spherical_test.sv]
// Self-checking testbench for the Cartesian-to-spherical converter.
// Drives points over valid/ready, predicts radius and Q1.15 ratios; needs c2s_pkg.
module cartesian_to_spherical_test;
    import c2s_pkg::*;

    logic aclk, aresetn;
    logic s_valid, s_ready, m_valid, m_ready, cfg_valid, cfg_ready;
    c2s_in_t s_data;
    c2s_out_t m_data;
    logic [LimW-1:0] cfg_data;

    typedef struct {
        c2s_in_t pt;
        logic have_res;
        c2s_out_t res;
    } dir_row_t;

    c2s_out_t pending_res[$];
    logic [LimW-1:0] limit_now;
    int errors = 0;
    int row_errors;
    bit hold_off, calm;
    dir_row_t dir_rows[$];

    cartesian_to_spherical dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
    );

    initial begin
        aclk = 0;
        forever #4 aclk = ~aclk;
    end

    initial begin
        #20000000;
        $display("TEST FAILED");
        $finish;
    end

    function automatic logic [31:0] int_root(logic [63:0] v);
        logic [63:0] res, bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > v) bitv >>= 2;
        while (bitv != 0) begin
            if (v >= res + bitv) begin
                v -= res + bitv;
                res = (res >> 1) + bitv;
            end else begin
                res >>= 1;
            end
            bitv >>= 2;
        end
        return res[31:0];
    endfunction

    function automatic logic signed [15:0] q15_ratio(longint num, longint den);
        longint mag, q;
        mag = num < 0 ? -num : num;
        q = (mag << 15) / den;
        if (q > 32767) q = 32767;
        return num < 0 ? 16'(-q) : 16'(q);
    endfunction

    function automatic c2s_out_t spherical_of(c2s_in_t p);
        longint x, y, z, sxy;
        logic [31:0] r, rxy;
        c2s_out_t o;
        x = p.coord_x;
        y = p.coord_y;
        z = p.coord_z;
        sxy = x * x + y * y;
        r = int_root(64'(sxy + z * z));
        rxy = int_root(64'(sxy));
        o.radius = r[15:0];
        o.cos_theta = QOne;
        o.sin_theta = '0;
        o.cos_phi = QOne;
        o.sin_phi = '0;
        if (r > limit_now) begin
            o.cos_theta = q15_ratio(z, r);
            o.sin_theta = QW'(q15_ratio(rxy, r));
            if (rxy > limit_now) begin
                o.cos_phi = q15_ratio(x, rxy);
                o.sin_phi = q15_ratio(y, rxy);
            end
        end
        return o;
    endfunction

    task automatic send_point(c2s_in_t p);
        while (!calm && $urandom_range(99) < 25) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data <= p;
        pending_res.push_back(spherical_of(p));
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic write_limit(logic [LimW-1:0] v);
        s_valid <= 1'b0;
        while (pending_res.size() != 0) @(posedge aclk);
        repeat (40) @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_data <= v;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        limit_now = v;
    endtask

    function automatic logic signed [15:0] rand_coord();
        case ($urandom_range(4))
            0: return 16'($urandom_range(600)) - 16'sd300;
            1: return $urandom_range(1) ? 16'sh7fff : 16'sh8000;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic dir_row_t row(int x, int y, int z, bit known, c2s_out_t r);
        dir_row_t d;
        d.pt = '{16'(x), 16'(y), 16'(z)};
        d.have_res = known;
        d.res = r;
        return d;
    endfunction

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (pending_res.size() == 0) begin
                $display("%0t: unexpected result %p", $time, m_data);
                errors <= errors + 1;
            end else begin
                if (m_data !== pending_res[0]) begin
                    $display("%0t: expected %p actual %p", $time, pending_res[0], m_data);
                    errors <= errors + 1;
                end
                void'(pending_res.pop_front());
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || hold_off) m_ready <= 1'b0;
        else m_ready <= calm || ($urandom_range(99) >= 25);
    end

    initial begin
        c2s_in_t p;
        int wait_cycles;
        aresetn = 0;
        s_valid = 0;
        s_data = '0;
        cfg_valid = 0;
        cfg_data = '0;
        row_errors = 0;
        hold_off = 0;
        calm = 0;
        limit_now = 0;
        repeat (9) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);

        dir_rows.push_back(row(0, 0, 0, 1, '{16'd0, QOne, 15'd0, QOne, QZero}));
        dir_rows.push_back(row(0, 0, 5, 1, '{16'd5, QOne, 15'd0, QOne, QZero}));
        dir_rows.push_back(row(0, 0, -5, 1, '{16'd5, -QOne, 15'd0, QOne, QZero}));
        dir_rows.push_back(row(7, 0, 0, 1, '{16'd7, QZero, 15'd32767, QOne, QZero}));
        dir_rows.push_back(row(-7, 0, 0, 1, '{16'd7, QZero, 15'd32767, -QOne, QZero}));
        dir_rows.push_back(row(0, 9, 0, 1, '{16'd9, QZero, 15'd32767, QZero, QOne}));
        dir_rows.push_back(row(0, -9, 0, 1, '{16'd9, QZero, 15'd32767, QZero, -QOne}));
        dir_rows.push_back(row(-32768, -32768, -32768, 0, '0));
        dir_rows.push_back(row(32767, 32767, 32767, 0, '0));
        dir_rows.push_back(row(-32768, 32767, -32768, 0, '0));
        dir_rows.push_back(row(1, 1, 0, 0, '0));
        dir_rows.push_back(row(1, 1, 1, 0, '0));
        dir_rows.push_back(row(3, 4, 12, 0, '0));
        dir_rows.push_back(row(-32768, 0, 0, 0, '0));
        dir_rows.push_back(row(0, 0, -32768, 0, '0));
        foreach (dir_rows[i]) begin
            send_point(dir_rows[i].pt);
            if (dir_rows[i].have_res && pending_res[$] !== dir_rows[i].res) begin
                $display("%0t: predictor row %0d expected %p actual %p", $time, i,
                         dir_rows[i].res, pending_res[$]);
                row_errors++;
            end
        end

        write_limit(8'd255);
        foreach (dir_rows[i]) send_point(dir_rows[i].pt);
        for (int i = 0; i < 20; i++) send_point('{16'($urandom_range(300)) - 16'sd150,
            16'($urandom_range(300)) - 16'sd150, 16'($urandom_range(600)) - 16'sd300});

        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: write_limit(8'd0);
                1: write_limit(LimW'($urandom));
                2: write_limit(8'd255);
                default: write_limit(8'd1);
            endcase
            calm = (ph == 2);
            for (int i = 0; i < 260; i++) begin
                if (ph == 1 && i == 50) begin
                    hold_off = 1;
                    fork
                        begin
                            wait_cycles = 200;
                            repeat (wait_cycles) @(posedge aclk);
                            hold_off = 0;
                        end
                    join_none
                end
                p.coord_x = rand_coord();
                p.coord_y = rand_coord();
                p.coord_z = rand_coord();
                send_point(p);
            end
        end
        calm = 0;
        s_valid <= 1'b0;

        while (pending_res.size() != 0) @(posedge aclk);
        repeat (60) @(posedge aclk);
        if (errors == 0 && row_errors == 0) $display("TEST PASSED");
        else $display("TEST FAILED");
        $finish;
    end
endmodule

[cartesian_to_spherical.f]
src/c2s_pkg.sv
src/c2s_sqrt.sv
src/c2s_div.sv
src/cartesian_to_spherical.sv
src/c2s_checker.sv
test/cartesian_to_spherical_test.sv
